// ----- design/mea_pkg.sv -----
package mea_pkg;

	localparam int BASE_W   = 62;
	localparam int EXP_W    = 63;
	localparam int RES_W    = 62;
	localparam int MODREG_W = 63;
	localparam int CNT_W    = $clog2(BASE_W);

	localparam logic [MODREG_W-1:0] MODULUS_RESET = 63'd1000000007;

	typedef struct packed {
		logic start;
		logic res_ready;
	} mea_cmd_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} mea_stat_t;

endpackage

// ----- design/mea_if.sv -----
interface mea_in_if;
	import mea_pkg::*;
	logic                valid;
	logic                ready;
	logic [BASE_W-1:0]   base;
	logic [EXP_W-1:0]    exponent;
	modport source (output valid, base, exponent, input ready);
	modport sink   (input valid, base, exponent, output ready);
endinterface

interface mea_out_if;
	import mea_pkg::*;
	logic                valid;
	logic                ready;
	logic [RES_W-1:0]    power_result;
	modport source (output valid, power_result, input ready);
	modport sink   (input valid, power_result, output ready);
endinterface

// ----- design/mea_modadd.sv -----
// y = (a + b + cin) mod m, for a, b < m and m <= 2^WIDTH
module mea_modadd #(
	parameter int WIDTH = 62
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic             cin,
	input  logic [WIDTH:0]   m,
	output logic [WIDTH-1:0] y
);
	logic [WIDTH:0] sum;
	logic [WIDTH:0] diff;

	assign sum  = {1'b0, a} + {1'b0, b} + (WIDTH+1)'(cin);
	assign diff = sum - m;
	assign y    = (sum >= m) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
endmodule

// ----- design/mea_core.sv -----
module mea_core #(
	parameter int MOD_WIDTH = 62,
	parameter int EXP_WIDTH = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mea_pkg::mea_cmd_t           cmd,
	output mea_pkg::mea_stat_t          stat,
	input  logic [mea_pkg::BASE_W-1:0]  base,
	input  logic [EXP_WIDTH-1:0]        exponent,
	input  logic [MOD_WIDTH:0]          modulus,
	output logic [MOD_WIDTH-1:0]        power
);
	import mea_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_REDUCE = 6'b000010,
		S_EXP    = 6'b000100,
		S_MADD   = 6'b001000,
		S_MDBL   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [MOD_WIDTH:0]     m_q;
	logic [BASE_W-1:0]      base_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [EXP_WIDTH-1:0]   e_q;
	logic [MOD_WIDTH-1:0]   r_q;
	logic [MOD_WIDTH-1:0]   pw_q;
	logic [MOD_WIDTH-1:0]   acc_q;
	logic [MOD_WIDTH-1:0]   dbl_q;
	logic [MOD_WIDTH-1:0]   mb_q;
	logic                   sq_q;
	logic                   mul_done_q;

	logic [MOD_WIDTH-1:0]   ua;
	logic [MOD_WIDTH-1:0]   ub;
	logic                   ucin;
	logic [MOD_WIDTH-1:0]   uy;
	logic [EXP_WIDTH-1:0]   e_rest;
	logic [MOD_WIDTH-1:0]   mb_rest;

	assign e_rest  = e_q >> 1;
	assign mb_rest = mb_q >> 1;

	// operand select for the shared modular adder
	always_comb begin
		ua   = dbl_q;
		ub   = dbl_q;
		ucin = 1'b0;
		unique case (state_q)
			S_REDUCE: begin
				ua   = pw_q;
				ub   = pw_q;
				ucin = base_q[BASE_W-1];
			end
			S_MADD: begin
				if (mb_q[0]) begin
					ua = acc_q;
					ub = dbl_q;
				end
			end
			default: begin
			end
		endcase
	end

	mea_modadd #(.WIDTH(MOD_WIDTH)) u_add (
		.a   (ua),
		.b   (ub),
		.cin (ucin),
		.m   (m_q),
		.y   (uy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						base_q     <= base;
						e_q        <= exponent;
						m_q        <= modulus;
						r_q        <= MOD_WIDTH'(1);
						pw_q       <= '0;
						cnt_q      <= CNT_W'(BASE_W - 1);
						mul_done_q <= 1'b0;
						state_q    <= S_REDUCE;
					end
				end
				// base mod m, one base bit per cycle, msb first
				S_REDUCE: begin
					pw_q   <= uy;
					base_q <= base_q << 1;
					cnt_q  <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					acc_q <= '0;
					mb_q  <= pw_q;
					// stop once no set exponent bit is left to fold in
					if (e_rest == '0 && (!e_q[0] || mul_done_q)) begin
						state_q <= S_DONE;
					end else if (e_q[0] && !mul_done_q) begin
						dbl_q   <= r_q;
						sq_q    <= 1'b0;
						state_q <= S_MADD;
					end else begin
						dbl_q   <= pw_q;
						sq_q    <= 1'b1;
						state_q <= S_MADD;
					end
				end
				S_MADD: begin
					if (mb_q == '0) begin
						if (sq_q) begin
							pw_q       <= acc_q;
							e_q        <= e_rest;
							mul_done_q <= 1'b0;
						end else begin
							r_q        <= acc_q;
							mul_done_q <= 1'b1;
						end
						state_q <= S_EXP;
					end else if (mb_q[0]) begin
						acc_q <= uy;
						if (mb_rest == '0) begin
							mb_q <= '0;
						end else begin
							state_q <= S_MDBL;
						end
					end else begin
						dbl_q <= uy;
						mb_q  <= mb_rest;
					end
				end
				S_MDBL: begin
					dbl_q   <= uy;
					mb_q    <= mb_rest;
					state_q <= S_MADD;
				end
				S_DONE: begin
					if (cmd.res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);
	assign power          = r_q;

	a_pw_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP) |-> ({1'b0, pw_q} < m_q))
		else $error("power register not reduced");

	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP) |-> ({1'b0, r_q} < m_q || r_q == MOD_WIDTH'(1)))
		else $error("running result not reduced");

	a_mul_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MADD && mb_q != '0) |->
		({1'b0, dbl_q} < m_q && {1'b0, acc_q} < m_q))
		else $error("product operand out of range");

	a_reduce_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cmd.start) |-> ##(BASE_W + 1) (state_q == S_EXP))
		else $error("base reduction length wrong");
endmodule

// ----- design/modular_exponentiation_top.sv -----
// Modular exponentiation: each operand beat (base, exponent) yields one result beat
// power_result = base^exponent mod modulus, right-to-left square and multiply, where
// every modular product is built by shift and add on one shared modular adder (one
// add-and-reduce per cycle). Exponent zero gives 1, even when the modulus is 1. The
// modulus register resets to 1000000007; a write of 0 acts as 1 and a value above
// 2^MOD_WIDTH saturates to 2^MOD_WIDTH. Only the low EXP_WIDTH exponent bits count.
// One item at a time: operand.ready is low while an item is in work. The base is
// first reduced mod m, one base bit at a time, msb first; then, per exponent bit up
// to the highest set one, a square (skipped after the highest set bit) and, for a
// set bit, a multiply; each product adds the doubled multiplicand for each set bit
// of the reduced power, up to its top set bit. A finished result sits in an output
// register so the next item can start while it waits.
module modular_exponentiation_top #(
	parameter int MOD_WIDTH = 62,
	parameter int EXP_WIDTH = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mea_pkg::MODREG_W-1:0]  cfg_wdata,
	mea_in_if.sink                        operand,
	mea_out_if.source                     result
);
	import mea_pkg::*;

	localparam logic [MODREG_W-1:0] LIMIT = MODREG_W'(1) << MOD_WIDTH;
	localparam logic [MOD_WIDTH:0]  EFF_RESET = (MODULUS_RESET > LIMIT) ?
		LIMIT[MOD_WIDTH:0] : MODULUS_RESET[MOD_WIDTH:0];

	logic [MOD_WIDTH:0]   eff_m_q;
	logic [MOD_WIDTH:0]   cfg_eff;
	mea_cmd_t             cmd;
	mea_stat_t            stat;
	logic [MOD_WIDTH-1:0] power;
	logic                 out_valid_q;
	logic [RES_W-1:0]     out_data_q;

	always_comb begin
		priority if (cfg_wdata == '0) begin
			cfg_eff = (MOD_WIDTH+1)'(1);
		end else if (cfg_wdata > LIMIT) begin
			cfg_eff = LIMIT[MOD_WIDTH:0];
		end else begin
			cfg_eff = cfg_wdata[MOD_WIDTH:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_m_q <= EFF_RESET;
		end else if (cfg_we) begin
			eff_m_q <= cfg_eff;
		end
	end

	assign cmd.start     = operand.valid & stat.idle;
	assign cmd.res_ready = !out_valid_q | result.ready;
	assign operand.ready = stat.idle;

	mea_core #(
		.MOD_WIDTH (MOD_WIDTH),
		.EXP_WIDTH (EXP_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.base     (operand.base),
		.exponent (operand.exponent[EXP_WIDTH-1:0]),
		.modulus  (eff_m_q),
		.power    (power)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_valid && cmd.res_ready) begin
			out_valid_q <= 1'b1;
			out_data_q  <= RES_W'(power);
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.power_result = out_data_q;
endmodule

// ----- dv/power_checker.sv -----
`timescale 1ns / 100ps
module power_checker #(
	parameter int MOD_WIDTH = 62,
	parameter int EXP_WIDTH = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mea_pkg::MODREG_W-1:0] cfg_wdata,
	mea_in_if                            operand,
	mea_out_if                           result,
	output int                           pending,
	output int                           errors
);
	import mea_pkg::*;

	logic [MODREG_W-1:0] modulus_q;
	logic [RES_W-1:0]    expected_powers[$];
	logic [RES_W-1:0]    want;

	// zero acts as one, anything above 2^MOD_WIDTH saturates
	function automatic logic [63:0] eff_modulus(input logic [MODREG_W-1:0] r);
		logic [63:0] cap;
		cap = 64'd1 << MOD_WIDTH;
		if (r == '0)
			return 64'd1;
		if (64'(r) > cap)
			return cap;
		return 64'(r);
	endfunction

	function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] m);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		prod = prod % {64'd0, m};
		return prod[63:0];
	endfunction

	// right-to-left square and multiply; the running product starts at 1 unreduced,
	// so exponent zero gives 1 even for modulus 1
	function automatic logic [RES_W-1:0] predict_power(input logic [BASE_W-1:0] b,
		input logic [EXP_W-1:0] e, input logic [MODREG_W-1:0] r);
		logic [63:0] m;
		logic [63:0] pw;
		logic [63:0] acc;
		int i;
		m   = eff_modulus(r);
		pw  = 64'(b) % m;
		acc = 64'd1;
		for (i = 0; i < EXP_WIDTH; i++) begin
			if (e[i])
				acc = mul_reduce(acc, pw, m);
			pw = mul_reduce(pw, pw, m);
		end
		return acc[RES_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
		input logic [RES_W-1:0] exp_val);
		errors = errors + 1;
		$display("[%0t] power_result %s: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q = MODULUS_RESET;
			expected_powers.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (operand.valid && operand.ready)
				expected_powers.insert(expected_powers.size(),
					predict_power(operand.base, operand.exponent, modulus_q));
			if (result.valid && result.ready) begin
				if (expected_powers.size() == 0) begin
					report_mismatch("beat with nothing outstanding", result.power_result, '0);
				end else begin
					want = expected_powers.pop_front();
					if (result.power_result !== want)
						report_mismatch("mismatch", result.power_result, want);
				end
			end
			// a write only lands between items, after any beat sampled at this edge
			if (cfg_we)
				modulus_q = cfg_wdata;
			pending <= expected_powers.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import mea_pkg::*;

	localparam int MOD_WIDTH = 62;
	localparam int EXP_WIDTH = 63;
	localparam logic [63:0] MOD_CAP = 64'd1 << MOD_WIDTH;
	localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
	localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
	localparam logic [EXP_W-1:0]  EXP_TOP  = {1'b1, {(EXP_W-1){1'b0}}};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [MODREG_W-1:0] cfg_wdata;
	int                  pending;
	int                  errors;
	logic [MODREG_W-1:0] cur_modulus;
	logic [MODREG_W-1:0] sweep[8];
	bit                  gaps_on;

	mea_in_if  operand_if ();
	mea_out_if result_if ();

	modular_exponentiation_top #(
		.MOD_WIDTH(MOD_WIDTH),
		.EXP_WIDTH(EXP_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operand   (operand_if),
		.result    (result_if)
	);

	power_checker #(
		.MOD_WIDTH(MOD_WIDTH),
		.EXP_WIDTH(EXP_WIDTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operand   (operand_if),
		.result    (result_if),
		.pending   (pending),
		.errors    (errors)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_operand(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		// valid stays up from the previous beat when there is no gap
		if (gap > 0) begin
			operand_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_if.valid    <= 1'b1;
		operand_if.base     <= b;
		operand_if.exponent <= e;
		do @(posedge clk); while (!operand_if.ready);
	endtask

	task automatic finish_phase();
		operand_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [MODREG_W-1:0] v);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		cur_modulus = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly short exponents to keep the run short, a quarter at full width
	task automatic run_random(input int count);
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] m;
		int sel;
		int k;
		for (k = 0; k < count; k++) begin
			m = (64'(cur_modulus) > MOD_CAP) ? MOD_CAP : 64'(cur_modulus);
			sel = $urandom_range(0, 9);
			b = rand64();
			if (sel == 0)
				b = 64'($urandom_range(0, 3));
			else if (sel == 1)
				b = m - 64'($urandom_range(0, 2));
			e = rand64();
			if ($urandom_range(0, 3) != 0)
				e = e & ((64'd1 << $urandom_range(0, 16)) - 64'd1);
			send_operand(b[BASE_W-1:0], e[EXP_W-1:0]);
		end
	endtask

	initial begin
		int n;
		result_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				result_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 2000) : $urandom_range(1, 20);
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		#100_000_000;
		$display("[modular_exponentiation_top] ERROR");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		operand_if.valid    <= 1'b0;
		operand_if.base     <= '0;
		operand_if.exponent <= '0;
		cur_modulus = MODULUS_RESET;
		gaps_on     = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus, edges of both fields
		send_operand('0, '0);
		send_operand('0, 63'd1);
		send_operand(BASE_MAX, '0);
		send_operand(BASE_MAX, EXP_MAX);
		send_operand(62'd1, EXP_MAX);
		send_operand(62'd2, 63'd1);
		send_operand(62'd2, 63'd62);
		send_operand(62'd3, 63'd1000000006);   // prime modulus, power m-1: gives 1
		send_operand(62'd1000000007, 63'd5);   // base equal to modulus
		send_operand(62'd1000000006, 63'd2);
		send_operand(62'd7, EXP_TOP);
		send_operand(62'h2aaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555);
		finish_phase();

		// modulus zero acts as one
		write_modulus('0);
		send_operand(62'd5, '0);
		send_operand(62'd5, 63'd3);
		send_operand('0, '0);
		finish_phase();

		// modulus one, exponent zero still gives 1
		write_modulus(63'd1);
		send_operand(62'd9, '0);
		send_operand(BASE_MAX, EXP_MAX);
		finish_phase();

		sweep = '{MOD_CAP[MODREG_W-1:0], {MODREG_W{1'b1}}, 63'(rand64() >> 1), 63'd97, 63'd2,
			63'($urandom), 63'd3, MOD_CAP[MODREG_W-1:0] - 63'd1};
		foreach (sweep[p]) begin
			gaps_on = (p % 3 != 2);
			write_modulus(sweep[p]);
			run_random(12);
			finish_phase();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[modular_exponentiation_top] OK");
		else
			$display("[modular_exponentiation_top] ERROR");
		$finish;
	end

endmodule
